FILE: hdl/sbmq_pkg.sv
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and constants of the shared-buffer multi-queue block: stream
// field layout, command and status codes, and the control/status structs
// that join the sequencer to the datapath.
// ----------------------------------------------------------------------------
package sbmq_pkg;

    localparam int CMD_W = 1;
    localparam int QID_W = 3;
    localparam int VAL_W = 31;
    localparam int STS_W = 3;
    localparam int CFG_W = 4;

    // Input word: command, queue_id, value from the lowest bit up.
    localparam int CMD_LSB     = 0;
    localparam int QID_LSB     = CMD_LSB + CMD_W;
    localparam int VAL_LSB     = QID_LSB + QID_W;
    localparam int IN_TDATA_W  = 40;

    // Result word: status, data_out from the lowest bit up.
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_PAD_W   = OUT_TDATA_W - STS_W - VAL_W;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [STS_W-1:0] {
        ST_ENQUEUED = 3'd0,
        ST_DEQUEUED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_BADQ     = 3'd4
    } status_t;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic capture;     // take the input word and read the queue record
        logic deq_read;    // read value and link of the queue head
        logic enq_commit;  // link the new entry and post an enqueued result
        logic deq_commit;  // unlink the head and post a dequeued result
        logic reject;      // post a bad queue, empty or full result
    } dp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic bad;
        logic is_deq;
        logic q_empty;
        logic store_full;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: hdl/shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue
// Several FIFO queues kept as linked lists in one shared entry store.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one operation per word: an enqueue of a value or
// a dequeue of the head, addressed to a queue. Every accepted word yields
// exactly one result word on the master stream with a status (enqueued,
// dequeued, empty, full, bad queue) and the dequeued value, zero otherwise.
// The cfg channel writes the number of active queues; it is ready whenever
// the block is out of reset.
// Timing: one word is worked on at a time. An enqueue or a rejected word
// reaches the output register from the access state, a dequeue from the
// update state, since the per-queue record is read first and the head's
// value and link only then. s_tready returns in the cycle the result is
// posted, so a new word is taken only once the last result is posted.
// The result register frees the sequencer: a stalled receiver only holds the
// next result back, and the block waits with it until m_tready.
// Reset empties all queues and sets the active queue count to 8. Unused
// entries are handed out from a fill counter, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue #(
    parameter int NUM_QUEUES = 8,
    parameter int CAPACITY   = 256
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // command [0], queue_id [3:1], value [34:4], zero fill above
    input  logic [sbmq_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status [2:0], data_out [33:3], zero fill above
    output logic [sbmq_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    // active_queues [3:0]
    input  logic [sbmq_pkg::CFG_W-1:0]          cfg_data
);
    import sbmq_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = aresetn;

    sbmq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sbmq_datapath #(
        .NUM_QUEUES (NUM_QUEUES),
        .CAPACITY   (CAPACITY)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

`ifndef ASSERT_OFF
    // Only one result can be posted in a cycle.
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.enq_commit, cmd.deq_commit, cmd.reject}))
        else $error("more than one result posted in one cycle");

    // A posted result shows up on the master side in the next cycle.
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.enq_commit || cmd.deq_commit || cmd.reject) |=> m_tvalid)
        else $error("posted result not presented");

    // A word is taken only through the handshake.
    a_capture_hs: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.capture |-> (s_tvalid && s_tready))
        else $error("word captured without handshake");

    // After a word is accepted, no second word is taken until it is done.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second word accepted while one is in flight");
`endif

endmodule

FILE: hdl/sbmq_ctrl.sv
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Sequencer of the multi-queue block: accepts one word, steps it through the
// memory lookups and commits the result when the output register is free.
// ----------------------------------------------------------------------------
module sbmq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  sbmq_pkg::dp_sts_t  sts,
    output sbmq_pkg::dp_cmd_t  cmd
);
    import sbmq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ACCESS,
        S_UPDATE
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg;

    assign s_tready = ready_reg;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && ready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = S_ACCESS;
                end
            end
            S_ACCESS: begin
                if (sts.bad || (sts.is_deq && sts.q_empty) ||
                    (!sts.is_deq && sts.store_full)) begin
                    if (sts.out_free) begin
                        cmd.reject = 1'b1;
                        state_next = S_IDLE;
                    end
                end else if (sts.is_deq) begin
                    cmd.deq_read = 1'b1;
                    state_next   = S_UPDATE;
                end else if (sts.out_free) begin
                    cmd.enq_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_UPDATE: begin
                if (sts.out_free) begin
                    cmd.deq_commit = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The input side stays closed during reset; ready is registered and opens in the cycle after reset is released.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ready_reg <= (state_next == S_IDLE);
        end
    end

endmodule

FILE: hdl/sbmq_datapath.sv
// ----------------------------------------------------------------------------
// sbmq_datapath
// Storage and result path of the multi-queue block: value and link memories,
// per-queue head/tail/count memory, free-list pointers and the output word.
// ----------------------------------------------------------------------------
module sbmq_datapath #(
    parameter int NUM_QUEUES = 8,
    parameter int CAPACITY   = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  sbmq_pkg::dp_cmd_t                     cmd,
    output sbmq_pkg::dp_sts_t                     sts,
    input  logic [sbmq_pkg::IN_TDATA_W-1:0]       s_tdata,
    input  logic                                  cfg_valid,
    input  logic [sbmq_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [sbmq_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import sbmq_pkg::*;

    localparam int PW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int QIW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
        logic [CW-1:0] count;
    } qword_t;

    // Memories.
    logic [VAL_W-1:0] value_mem [CAPACITY];
    logic [PW-1:0]    link_mem  [CAPACITY];
    qword_t           queue_mem [NUM_QUEUES];

    // Configuration and free-list state.
    logic [CFG_W-1:0]      active_reg;
    logic [CW-1:0]         free_cnt_reg;
    logic [CW-1:0]         fill_reg;
    logic [PW-1:0]         rec_head_reg;
    logic [NUM_QUEUES-1:0] qvalid_reg;

    // Captured input word and registered reads.
    logic             cmd_reg;
    logic [QID_W-1:0] q_reg;
    logic [VAL_W-1:0] val_reg;
    qword_t           qrd_reg;
    logic             qv_rd_reg;
    logic [PW-1:0]    lrd_reg;
    logic [VAL_W-1:0] vrd_reg;

    // Output word.
    logic             m_valid_reg;
    status_t          status_reg;
    logic [VAL_W-1:0] data_reg;

    logic [QIW-1:0] qidx_in;
    logic [QIW-1:0] qidx_reg;
    logic [CW-1:0]  cnt_w;
    logic           fresh;
    logic [PW-1:0]  new_e;
    logic           bad_w;
    logic           link_we;
    logic [PW-1:0]  link_wa;
    logic [PW-1:0]  link_wd;
    logic           q_we;
    qword_t         q_wd;
    status_t        reject_status;
    logic           load_out;

    assign qidx_in  = QIW'(s_tdata[QID_LSB +: QID_W]);
    assign qidx_reg = QIW'(q_reg);

    // A queue never written reads as empty; its pointers are never used then.
    assign cnt_w = qv_rd_reg ? qrd_reg.count : '0;

    // Entries never handed out yet come from the fill counter, so the link
    // memory needs no initial sweep; returned entries form the recycle list.
    assign fresh = (fill_reg != CW'(CAPACITY));
    assign new_e = fresh ? fill_reg[PW-1:0] : rec_head_reg;

    assign bad_w = ({1'b0, q_reg} >= active_reg) || (32'(q_reg) >= NUM_QUEUES);

    assign sts.bad        = bad_w;
    assign sts.is_deq     = (cmd_reg == CMD_DEQ);
    assign sts.q_empty    = (cnt_w == '0);
    assign sts.store_full = (free_cnt_reg == '0);
    assign sts.out_free   = !m_valid_reg || m_tready;

    assign link_we = cmd.deq_commit || (cmd.enq_commit && (cnt_w != '0));
    assign link_wa = cmd.deq_commit ? qrd_reg.head : qrd_reg.tail;
    assign link_wd = cmd.deq_commit ? rec_head_reg : new_e;

    assign q_we = cmd.enq_commit || cmd.deq_commit;

    always_comb begin
        if (cmd.deq_commit) begin
            q_wd.head  = lrd_reg;
            q_wd.tail  = qrd_reg.tail;
            q_wd.count = cnt_w - CW'(1);
        end else begin
            q_wd.head  = (cnt_w == '0) ? new_e : qrd_reg.head;
            q_wd.tail  = new_e;
            q_wd.count = cnt_w + CW'(1);
        end
    end

    always_comb begin
        priority if (bad_w) begin
            reject_status = ST_BADQ;
        end else if (cmd_reg == CMD_DEQ) begin
            reject_status = ST_EMPTY;
        end else begin
            reject_status = ST_FULL;
        end
    end

    assign load_out = cmd.enq_commit || cmd.deq_commit || cmd.reject;

    // Memory ports.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            qrd_reg <= queue_mem[qidx_in];
        end
        if (q_we) begin
            queue_mem[qidx_reg] <= q_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lrd_reg <= link_mem[rec_head_reg];
        end else if (cmd.deq_read) begin
            lrd_reg <= link_mem[qrd_reg.head];
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.deq_read) begin
            vrd_reg <= value_mem[qrd_reg.head];
        end
        if (cmd.enq_commit) begin
            value_mem[new_e] <= val_reg;
        end
    end

    // Captured input word.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg   <= s_tdata[CMD_LSB];
            q_reg     <= s_tdata[QID_LSB +: QID_W];
            val_reg   <= s_tdata[VAL_LSB +: VAL_W];
            qv_rd_reg <= qvalid_reg[qidx_in];
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg   <= ACTIVE_RESET;
            free_cnt_reg <= CW'(CAPACITY);
            fill_reg     <= '0;
            rec_head_reg <= '0;
            qvalid_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                active_reg <= cfg_data;
            end
            if (cmd.enq_commit) begin
                free_cnt_reg         <= free_cnt_reg - CW'(1);
                qvalid_reg[qidx_reg] <= 1'b1;
                if (fresh) begin
                    fill_reg <= fill_reg + CW'(1);
                end else begin
                    rec_head_reg <= lrd_reg;
                end
            end else if (cmd.deq_commit) begin
                free_cnt_reg <= free_cnt_reg + CW'(1);
                rec_head_reg <= qrd_reg.head;
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Output word payload.
    always_ff @(posedge aclk) begin
        if (cmd.enq_commit) begin
            status_reg <= ST_ENQUEUED;
            data_reg   <= '0;
        end else if (cmd.deq_commit) begin
            status_reg <= ST_DEQUEUED;
            data_reg   <= vrd_reg;
        end else if (cmd.reject) begin
            status_reg <= reject_status;
            data_reg   <= '0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, data_reg, status_reg};

endmodule
